FILE: rtl/core/mctmr_pkg.sv
// Package for the multi-channel periodic timer: request and response codes,
// field widths and the slot memory word layout. No dependencies.
`default_nettype none

package mctmr_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam int PERIOD_W = 32;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 3;
  localparam int REQ_W    = 2;
  localparam int TDATA_W  = 40;

  // slot memory word: reload value in the upper half, down-counter in the lower
  localparam int MEM_W = 2 * PERIOD_W;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REG   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNREG = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SETEN = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FIRE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REG  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/multi_channel_periodic_timer_top.sv
// Multi-channel periodic timer: top level with the request sequencer, the
// shared slot update unit and the output register. Uses mctmr_pkg, mctmr_slot_mem.
//
// Usage: requests arrive as words on the in_ stream (tuser = request type),
// responses leave on the out_ stream (tuser = response kind, tlast marks the
// final response of a request). Requests: tick, register, unregister, set
// enable. One request is taken at a time; in_tready is high only while the
// sequencer is idle.
// Timing: register and error answers are loaded from the decode state; unregister
// and set enable pass through a write state first. A tick scans the live slots in
// order: each enabled slot is read from the slot memory and written back through
// the single update unit, while a disabled one is skipped without a read. The
// next request is taken the cycle after the final answer is loaded.
// Reset (synchronous, rst_n low) empties the table, clears all enables and the
// tick count; the slot memory needs no clearing since only live slots are read.
// When the receiver stalls, a response waits in the output register; a tick
// with several firing slots pauses its scan until the previous word is taken.
`default_nettype none

module multi_channel_periodic_timer_top
  import mctmr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // period_ticks[31:0], slot_id[35:32], enable_value[36], zero fill
  input  wire logic [TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  wire logic [REQ_W-1:0]    in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // resp_slot[3:0], success[4], now_ticks[36:5], zero fill
  output logic [TDATA_W-1:0]       out_tdata,
  // resp_kind[2:0]
  output logic [KIND_W-1:0]        out_tuser,
  output logic                     out_tlast
);

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int LIVE_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (LIVE_W > SLOT_W) ? LIVE_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_WR, S_MOVE_WR, S_SETEN_WR, S_RESP
  } state_t;

  state_t                  state_r;
  logic [REQ_W-1:0]        req_r;
  logic [PERIOD_W-1:0]     period_r;
  logic [SLOT_W-1:0]       id_r;
  logic                    enval_r;
  logic [LIVE_W-1:0]       live_r;
  logic [LIVE_W-1:0]       idx_r;
  logic [PERIOD_W-1:0]     tick_r;
  logic [NUM_SLOTS-1:0]    en_r;
  logic                    pend_vld_r;
  logic [IDX_W-1:0]        pend_slot_r;
  logic [KIND_W-1:0]       res_kind_r;
  logic [SLOT_W-1:0]       res_slot_r;
  logic                    res_ok_r;
  logic                    out_vld_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic                    out_ok_r;
  logic [PERIOD_W-1:0]     out_now_r;
  logic                    out_last_r;

  logic                    mem_wr_en;
  logic [IDX_W-1:0]        mem_wr_addr;
  logic [MEM_W-1:0]        mem_wr_data;
  logic                    mem_rd_en;
  logic [IDX_W-1:0]        mem_rd_addr;
  logic [MEM_W-1:0]        mem_rd_data;

  logic [IDX_W-1:0]        idx_a;
  logic [IDX_W-1:0]        live_a;
  logic [IDX_W-1:0]        id_a;
  logic [LIVE_W-1:0]       live_m1;
  logic [IDX_W-1:0]        last_a;
  logic                    id_bad;
  logic                    full;
  logic                    out_free;
  logic                    out_load;
  logic [PERIOD_W-1:0]     rd_reload;
  logic [PERIOD_W-1:0]     rd_cnt;
  logic                    cnt_zero;
  logic [PERIOD_W-1:0]     cnt_dec;
  logic                    step_ok;

  assign idx_a    = idx_r[IDX_W-1:0];
  assign live_a   = live_r[IDX_W-1:0];
  assign id_a     = IDX_W'(id_r);
  assign live_m1  = live_r - LIVE_W'(1);
  assign last_a   = live_m1[IDX_W-1:0];
  assign id_bad   = CMP_W'(id_r) >= CMP_W'(live_r);
  assign full     = live_r == LIVE_W'(NUM_SLOTS);
  assign out_free = !out_vld_r || out_tready;

  // shared slot update unit: zero test and decrement of one counter
  assign rd_reload = mem_rd_data[MEM_W-1:PERIOD_W];
  assign rd_cnt    = mem_rd_data[PERIOD_W-1:0];
  assign cnt_zero  = rd_cnt == '0;
  assign cnt_dec   = rd_cnt - PERIOD_W'(1);
  // a second fire must wait until the previous fire word can be sent
  assign step_ok   = !(cnt_zero && pend_vld_r && !out_free);

  // output register takes a new word this cycle
  assign out_load = (state_r == S_SCAN_WR && step_ok && cnt_zero && pend_vld_r) ||
                    (state_r == S_RESP && out_free);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_now_r, out_ok_r, out_slot_r};

  mctmr_slot_mem #(
    .DEPTH(NUM_SLOTS)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_a;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_a;
    unique case (state_r)
      S_DECODE: begin
        if (req_r == REQ_REG && !full) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = live_a;
          mem_wr_data = {period_r - PERIOD_W'(1), {PERIOD_W{1'b0}}};
        end else if (req_r == REQ_UNREG && !id_bad) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = last_a;
        end else if (req_r == REQ_SETEN && !id_bad) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = id_a;
        end
      end
      S_SCAN_RD: begin
        if (idx_r != live_r && en_r[idx_a]) begin
          mem_rd_en = 1'b1;
        end
      end
      S_SCAN_WR: begin
        if (step_ok) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = cnt_zero ? {rd_reload, rd_reload} : {rd_reload, cnt_dec};
        end
      end
      S_MOVE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = id_a;
      end
      S_SETEN_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = id_a;
        mem_wr_data = {rd_reload, rd_reload};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      live_r     <= '0;
      tick_r     <= '0;
      en_r       <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_tready && !out_load) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r    <= in_tuser;
            period_r <= in_tdata[PERIOD_W-1:0];
            id_r     <= in_tdata[PERIOD_W+SLOT_W-1:PERIOD_W];
            enval_r  <= in_tdata[PERIOD_W+SLOT_W];
            state_r  <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_kind_r <= KIND_ERR;
          res_slot_r <= '0;
          res_ok_r   <= 1'b0;
          state_r    <= S_RESP;
          unique case (req_r)
            REQ_TICK: begin
              idx_r      <= '0;
              pend_vld_r <= 1'b0;
              state_r    <= S_SCAN_RD;
            end
            REQ_REG: begin
              if (!full) begin
                en_r[live_a] <= 1'b1;
                live_r       <= live_r + LIVE_W'(1);
                res_kind_r   <= KIND_REG;
                res_slot_r   <= SLOT_W'(live_r);
                res_ok_r     <= 1'b1;
              end
            end
            REQ_UNREG: begin
              if (!id_bad) begin
                live_r     <= live_m1;
                en_r[id_a] <= en_r[last_a];
                state_r    <= S_MOVE_WR;
              end
            end
            REQ_SETEN: begin
              if (!id_bad) begin
                en_r[id_a] <= enval_r;
                state_r    <= S_SETEN_WR;
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN_RD: begin
          if (idx_r == live_r) begin
            tick_r     <= tick_r + PERIOD_W'(1);
            res_kind_r <= pend_vld_r ? KIND_FIRE : KIND_IDLE;
            res_slot_r <= pend_vld_r ? SLOT_W'(pend_slot_r) : '0;
            res_ok_r   <= 1'b1;
            state_r    <= S_RESP;
          end else if (en_r[idx_a]) begin
            state_r <= S_SCAN_WR;
          end else begin
            idx_r <= idx_r + LIVE_W'(1);
          end
        end
        S_SCAN_WR: begin
          if (step_ok) begin
            if (cnt_zero) begin
              if (pend_vld_r) begin
                out_vld_r  <= 1'b1;
                out_kind_r <= KIND_FIRE;
                out_slot_r <= SLOT_W'(pend_slot_r);
                out_ok_r   <= 1'b1;
                out_now_r  <= tick_r + PERIOD_W'(1);
                out_last_r <= 1'b0;
              end
              pend_vld_r  <= 1'b1;
              pend_slot_r <= idx_a;
            end
            idx_r   <= idx_r + LIVE_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_MOVE_WR, S_SETEN_WR: begin
          res_kind_r <= KIND_DONE;
          res_slot_r <= '0;
          res_ok_r   <= 1'b1;
          state_r    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            out_kind_r <= res_kind_r;
            out_slot_r <= res_slot_r;
            out_ok_r   <= res_ok_r;
            out_now_r  <= tick_r;
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_W'(NUM_SLOTS))
    else $error("live slot count exceeds table size");

  // a non-final fire word is always followed by more work on the same tick
  a_mid_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_last_r) |-> (state_r != S_IDLE))
    else $error("non-final word pending while sequencer idle");

  a_reg_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && req_r == REQ_REG && !full)
      |=> (live_r == $past(live_r) + LIVE_W'(1)))
    else $error("register did not grow the table");

endmodule

`default_nettype wire

FILE: rtl/core/mctmr_slot_mem.sv
// Slot memory of the periodic timer: one write port, one read port with
// registered read data. Depends on mctmr_pkg for the word width.
`default_nettype none

module mctmr_slot_mem
  import mctmr_pkg::*;
#(
  parameter int DEPTH = NUM_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [MEM_W-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [MEM_W-1:0]           rd_data
);

  logic [MEM_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for multi_channel_periodic_timer_top: directed and random request
// streams with a self-checking slot table predictor. Depends on mctmr_pkg.
`timescale 1ns / 1ps

module tb;
  import mctmr_pkg::*;

  localparam int SLOTS     = NUM_SLOTS_DEF;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 40;
  localparam int IDLE_PCT  = 22;
  localparam int MAX_SHOWN = 20;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic                ok;
    logic [PERIOD_W-1:0] now;
    logic                fin;
  } resp_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]    in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]   out_tuser;
  logic                out_tlast;

  // predicted slot table
  logic [PERIOD_W-1:0] reload_val [SLOTS];
  logic [PERIOD_W-1:0] down_cnt   [SLOTS];
  logic                slot_en    [SLOTS];
  int                  live_cnt;
  logic [PERIOD_W-1:0] tick_count;

  resp_t pending_resp [$];

  bit idling;
  int cycles;
  int errors;
  int n_words;
  int n_fires;
  int n_rejects;
  int n_full;
  int peak_live;

  multi_channel_periodic_timer_top #(.NUM_SLOTS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout, %0d responses still expected", $time, pending_resp.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (idling)
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    else
      out_tready <= 1'b1;
  end

  task automatic push_resp(input logic [KIND_W-1:0] kind, input int slot, input logic ok,
                           input logic fin);
    resp_t r;
    r.kind = kind;
    r.slot = slot[SLOT_W-1:0];
    r.ok   = ok;
    r.now  = tick_count;
    r.fin  = fin;
    pending_resp.push_back(r);
  endtask

  // updates the table copy for one accepted request and queues its responses
  task automatic timer_predict(input logic [REQ_W-1:0] req, input logic [PERIOD_W-1:0] period,
                               input logic [SLOT_W-1:0] id, input logic en_val);
    int fired [$];
    case (req)
      REQ_TICK: begin
        for (int s = 0; s < live_cnt; s++) begin
          if (slot_en[s]) begin
            if (down_cnt[s] == 0) begin
              down_cnt[s] = reload_val[s];
              fired.push_back(s);
            end else begin
              down_cnt[s] = down_cnt[s] - 1;
            end
          end
        end
        tick_count = tick_count + 1;
        if (fired.size() == 0)
          push_resp(KIND_IDLE, 0, 1'b1, 1'b1);
        foreach (fired[k])
          push_resp(KIND_FIRE, fired[k], 1'b1, k == fired.size() - 1);
        n_fires += fired.size();
      end
      REQ_REG: begin
        if (live_cnt >= SLOTS) begin
          push_resp(KIND_ERR, 0, 1'b0, 1'b1);
          n_full++;
          n_rejects++;
        end else begin
          reload_val[live_cnt] = period - 1;
          down_cnt[live_cnt]   = '0;
          slot_en[live_cnt]    = 1'b1;
          push_resp(KIND_REG, live_cnt, 1'b1, 1'b1);
          live_cnt++;
          if (live_cnt > peak_live)
            peak_live = live_cnt;
        end
      end
      REQ_UNREG: begin
        if (id >= live_cnt) begin
          push_resp(KIND_ERR, 0, 1'b0, 1'b1);
          n_rejects++;
        end else begin
          live_cnt--;
          reload_val[id] = reload_val[live_cnt];
          down_cnt[id]   = down_cnt[live_cnt];
          slot_en[id]    = slot_en[live_cnt];
          push_resp(KIND_DONE, 0, 1'b1, 1'b1);
        end
      end
      default: begin
        if (id >= live_cnt) begin
          push_resp(KIND_ERR, 0, 1'b0, 1'b1);
          n_rejects++;
        end else begin
          slot_en[id]  = en_val;
          down_cnt[id] = reload_val[id];
          push_resp(KIND_DONE, 0, 1'b1, 1'b1);
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [PERIOD_W-1:0] period,
                           input logic [SLOT_W-1:0] id, input logic en_val);
    int gap;
    gap = 0;
    if (idling && $urandom_range(99) < IDLE_PCT)
      gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, en_val, id, period};
    do @(posedge clk); while (!in_tready);
    timer_predict(req, period, id, en_val);
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_resp.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    resp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resp.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t unexpected word: kind %0d slot %0d", $time, out_tuser, out_tdata[3:0]);
      end else begin
        exp_r = pending_resp.pop_front();
        if (out_tuser !== exp_r.kind || out_tdata[3:0] !== exp_r.slot ||
            out_tdata[4] !== exp_r.ok || out_tdata[36:5] !== exp_r.now ||
            out_tlast !== exp_r.fin) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t mismatch expected kind %0d slot %0d ok %0d now %0d last %0d",
                     $time, exp_r.kind, exp_r.slot, exp_r.ok, exp_r.now, exp_r.fin);
            $display("%0t            actual kind %0d slot %0d ok %0d now %0d last %0d",
                     $time, out_tuser, out_tdata[3:0], out_tdata[4], out_tdata[36:5],
                     out_tlast);
          end
        end
      end
    end
  end

  task automatic test_directed;
    idling = 1'b0;
    send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);            // empty table: no fire
    send_word(REQ_UNREG, 32'd0, 4'd0, 1'b0);           // nothing to remove
    send_word(REQ_SETEN, 32'd0, 4'd0, 1'b1);
    send_word(REQ_REG, 32'd1, 4'd0, 1'b0);             // fires every tick
    send_word(REQ_REG, 32'd0, 4'd15, 1'b1);            // zero period wraps
    send_word(REQ_REG, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_word(REQ_REG, 32'd3, 4'd0, 1'b0);
    send_word(REQ_TICK, 32'hFFFF_FFFF, 4'd15, 1'b1);   // all four fire
    send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);
    send_word(REQ_SETEN, 32'd0, 4'd3, 1'b0);
    send_word(REQ_SETEN, 32'd0, 4'd15, 1'b1);          // id beyond live count
    send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);
    send_word(REQ_SETEN, 32'd0, 4'd3, 1'b1);
    repeat (3) send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);
    send_word(REQ_UNREG, 32'd0, 4'd0, 1'b0);           // last slot moves to 0
    send_word(REQ_UNREG, 32'd0, 4'd2, 1'b0);           // removing the last slot
    send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);
    send_word(REQ_UNREG, 32'd0, 4'd5, 1'b0);
    send_word(REQ_REG, 32'hA5A5_5A5A, 4'd10, 1'b0);
    send_word(REQ_TICK, 32'd0, 4'd0, 1'b0);
    drain();
  endtask

  task automatic random_word(input bit grow);
    int pick;
    int reg_w;
    int unreg_w;
    logic [REQ_W-1:0]    req;
    logic [PERIOD_W-1:0] period;
    logic [SLOT_W-1:0]   id;
    pick    = $urandom_range(99);
    reg_w   = grow ? 40 : 10;
    unreg_w = grow ? 10 : 35;
    if (pick < reg_w)
      req = REQ_REG;
    else if (pick < reg_w + unreg_w)
      req = REQ_UNREG;
    else if (pick < reg_w + unreg_w + 15)
      req = REQ_SETEN;
    else
      req = REQ_TICK;

    pick = $urandom_range(99);
    if (pick < 65)
      period = $urandom_range(1, 4);
    else if (pick < 80)
      period = $urandom_range(5, 20);
    else if (pick < 92)
      period = $urandom();
    else if (pick < 96)
      period = 32'd0;
    else
      period = 32'hFFFF_FFFF;

    if (live_cnt > 0 && $urandom_range(99) < 80)
      id = SLOT_W'($urandom_range(live_cnt - 1));
    else
      id = SLOT_W'($urandom_range(SLOTS - 1));

    send_word(req, period, id, $urandom_range(99) < 70);
  endtask

  task automatic test_random(input int count, input bit with_idling);
    idling = with_idling;
    for (int n = 0; n < count; n++)
      random_word((n / 40) % 2 == 0);
    drain();
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_TICK;
    out_tready = 1'b0;
    idling     = 1'b0;
    cycles     = 0;
    errors     = 0;
    n_words    = 0;
    n_fires    = 0;
    n_rejects  = 0;
    n_full     = 0;
    peak_live  = 0;
    live_cnt   = 0;
    tick_count = '0;
    for (int s = 0; s < SLOTS; s++) begin
      reload_val[s] = '0;
      down_cnt[s]   = '0;
      slot_en[s]    = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(120, 1'b0);
    test_random(360, 1'b1);

    repeat (SETTLE) @(posedge clk);
    $display("%0d request words, %0d slot fires, %0d rejected (%0d on a full table)",
             n_words, n_fires, n_rejects, n_full);
    $display("peak of %0d live slots, %0d ticks, %0d errors", peak_live, tick_count, errors);
    if (errors == 0 && pending_resp.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
